FILE: rtl/plm_pkg.sv
// ----------------------------------------------------------------------------
// plm_pkg
// Shared types, widths and codes of the ping link quality monitor.
// ----------------------------------------------------------------------------
package plm_pkg;

    localparam int PEER_INDEX_BITS  = 8;
    localparam int FRACTION_BITS    = 16;
    localparam int MIN_PACKET_BYTES = 20;

    localparam int PEER_W   = 8;
    localparam int LENGTH_W = 11;
    localparam int MAGIC_W  = 32;
    localparam int KIND_W   = 8;
    localparam int SEQ_W    = 32;
    localparam int TIME_W   = 64;
    localparam int COUNT_W  = 32;
    localparam int NOMINAL_W = 20;
    localparam int GAIN_W   = 17;
    localparam int GAIN_FRAC = 16;
    localparam int WHOLE_US_W = 32;
    localparam int LEVEL_W  = WHOLE_US_W + FRACTION_BITS;
    localparam int LEVEL_OUT_W = 48;
    localparam int STATUS_W = 2;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << GAIN_FRAC);
    localparam logic [PEER_W-1:0] PEER_MASK =
        PEER_W'((64'd1 << PEER_INDEX_BITS) - 64'd1);
    localparam logic [LENGTH_W-1:0] MIN_LENGTH = LENGTH_W'(MIN_PACKET_BYTES);

    localparam logic [MAGIC_W-1:0]   MAGIC_RESET       = 32'h5050_4D4F;
    localparam logic [NOMINAL_W-1:0] NOMINAL_RESET     = NOMINAL_W'(16700);
    localparam logic [GAIN_W-1:0]    JITTER_GAIN_RESET = GAIN_W'(3277);
    localparam logic [GAIN_W-1:0]    RTT_GAIN_RESET    = GAIN_W'(6554);

    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL_GAP = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_JITTER_GAIN = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_RTT_GAIN    = CFG_IDX_W'(3);

    localparam logic [KIND_W-1:0] KIND_PING = KIND_W'(0);

    typedef enum logic [STATUS_W-1:0] {
        ST_DROP = 2'd0,
        ST_PING = 2'd1,
        ST_PONG = 2'd2
    } t_status;

    typedef struct packed {
        logic [PEER_W-1:0]   peer;
        logic [LENGTH_W-1:0] length;
        logic [MAGIC_W-1:0]  packet_magic;
        logic [KIND_W-1:0]   kind;
        logic [SEQ_W-1:0]    sequence_req;
        logic [TIME_W-1:0]   sent_time;
        logic [TIME_W-1:0]   arrival_time;
    } t_item;

    typedef struct packed {
        t_status               status;
        logic [PEER_W-1:0]     echo_peer;
        logic [SEQ_W-1:0]      echo_sequence;
        logic [TIME_W-1:0]     echo_sent_time;
        logic [COUNT_W-1:0]    received_count;
        logic [COUNT_W-1:0]    lost_total;
        logic [LEVEL_OUT_W-1:0] jitter_level;
        logic [LEVEL_OUT_W-1:0] rtt_level;
        logic                  rtt_ready;
        logic [COUNT_W-1:0]    pong_count;
        logic [PEER_W-1:0]     locked_peer_index;
    } t_result;

    typedef struct packed {
        logic [MAGIC_W-1:0]   magic_word;
        logic [NOMINAL_W-1:0] nominal_gap_us;
        logic [GAIN_W-1:0]    jitter_gain;
        logic [GAIN_W-1:0]    rtt_gain;
    } t_cfg;

endpackage

FILE: rtl/plm_ifs.sv
// ----------------------------------------------------------------------------
// plm_ifs
// Valid/ready channels of the monitor: packet input, result output, config.
// ----------------------------------------------------------------------------
interface plm_in_if;
    import plm_pkg::*;

    logic                valid;
    logic                ready;
    logic [PEER_W-1:0]   peer;
    logic [LENGTH_W-1:0] length;
    logic [MAGIC_W-1:0]  packet_magic;
    logic [KIND_W-1:0]   kind;
    logic [SEQ_W-1:0]    sequence_req;
    logic [TIME_W-1:0]   sent_time;
    logic [TIME_W-1:0]   arrival_time;

    modport source (
        output valid, peer, length, packet_magic, kind, sequence_req, sent_time,
               arrival_time,
        input  ready
    );
    modport sink (
        input  valid, peer, length, packet_magic, kind, sequence_req, sent_time,
               arrival_time,
        output ready
    );
endinterface

interface plm_out_if;
    import plm_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [PEER_W-1:0]      echo_peer;
    logic [SEQ_W-1:0]       echo_sequence;
    logic [TIME_W-1:0]      echo_sent_time;
    logic [COUNT_W-1:0]     received_count;
    logic [COUNT_W-1:0]     lost_total;
    logic [LEVEL_OUT_W-1:0] jitter_level;
    logic [LEVEL_OUT_W-1:0] rtt_level;
    logic                   rtt_ready;
    logic [COUNT_W-1:0]     pong_count;
    logic [PEER_W-1:0]      locked_peer_index;

    modport source (
        output valid, status, echo_peer, echo_sequence, echo_sent_time,
               received_count, lost_total, jitter_level, rtt_level, rtt_ready,
               pong_count, locked_peer_index,
        input  ready
    );
    modport sink (
        input  valid, status, echo_peer, echo_sequence, echo_sent_time,
               received_count, lost_total, jitter_level, rtt_level, rtt_ready,
               pong_count, locked_peer_index,
        output ready
    );
endinterface

interface plm_cfg_if;
    import plm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink (input valid, reg_index, wdata, output ready);
endinterface

FILE: rtl/plm_cfg.sv
// ----------------------------------------------------------------------------
// plm_cfg
// Configuration register file written through the config channel.
// ----------------------------------------------------------------------------
module plm_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr,
    input  logic [plm_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [plm_pkg::CFG_DATA_W-1:0] i_data,
    output plm_pkg::t_cfg                  o_cfg
);
    import plm_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic_word     <= MAGIC_RESET;
            r_cfg.nominal_gap_us <= NOMINAL_RESET;
            r_cfg.jitter_gain    <= JITTER_GAIN_RESET;
            r_cfg.rtt_gain       <= RTT_GAIN_RESET;
        end else if (i_wr) begin
            unique case (i_index)
                CFG_MAGIC_WORD:  r_cfg.magic_word     <= i_data[MAGIC_W-1:0];
                CFG_NOMINAL_GAP: r_cfg.nominal_gap_us <= i_data[NOMINAL_W-1:0];
                CFG_JITTER_GAIN: r_cfg.jitter_gain    <= i_data[GAIN_W-1:0];
                CFG_RTT_GAIN:    r_cfg.rtt_gain       <= i_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/plm_ewma.sv
// ----------------------------------------------------------------------------
// plm_ewma
// One EWMA step: moves the average toward the sample by the gain-scaled
// distance, rounded toward zero.
// ----------------------------------------------------------------------------
module plm_ewma (
    input  logic [plm_pkg::LEVEL_W-1:0] i_avg,
    input  logic [plm_pkg::LEVEL_W-1:0] i_sample,
    input  logic [plm_pkg::GAIN_W-1:0]  i_gain,
    output logic [plm_pkg::LEVEL_W-1:0] o_avg
);
    import plm_pkg::*;

    localparam int PROD_W = LEVEL_W + GAIN_W;

    logic                 up;
    logic [GAIN_W-1:0]    gain_sat;
    logic [LEVEL_W-1:0]   distance;
    logic [PROD_W-1:0]    prod;
    logic [LEVEL_W-1:0]   step;

    always_comb begin
        up       = (i_sample >= i_avg);
        gain_sat = (i_gain > GAIN_ONE) ? GAIN_ONE : i_gain;
        distance = up ? (i_sample - i_avg) : (i_avg - i_sample);
        prod     = PROD_W'(distance) * PROD_W'(gain_sat);
        step     = prod[GAIN_FRAC +: LEVEL_W];
        o_avg    = up ? (i_avg + step) : (i_avg - step);
    end

endmodule

FILE: rtl/plm_proc.sv
// ----------------------------------------------------------------------------
// plm_proc
// Link statistics state and the per-packet update that produces one result.
// ----------------------------------------------------------------------------
module plm_proc (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  plm_pkg::t_item    i_item,
    input  plm_pkg::t_cfg     i_cfg,
    output plm_pkg::t_result  o_result
);
    import plm_pkg::*;

    logic [SEQ_W-1:0]   r_last_sequence, n_last_sequence;
    logic [COUNT_W-1:0] r_ping_count, n_ping_count;
    logic [COUNT_W-1:0] r_loss_count, n_loss_count;
    logic [TIME_W-1:0]  r_last_arrival, n_last_arrival;
    logic               r_arrival_seen, n_arrival_seen;
    logic [LEVEL_W-1:0] r_jitter_average, n_jitter_average;
    logic [LEVEL_W-1:0] r_rtt_average, n_rtt_average;
    logic               r_rtt_seeded, n_rtt_seeded;
    logic [COUNT_W-1:0] r_pongs_seen, n_pongs_seen;
    logic [PEER_W-1:0]  r_locked_peer, n_locked_peer;
    logic               r_peer_is_locked, n_peer_is_locked;

    logic                  pass;
    logic                  is_ping;
    logic [PEER_W-1:0]     peer_m;
    logic [SEQ_W:0]        last_plus_one;
    logic                  seq_gap;
    logic [TIME_W-1:0]     arr_gap;
    logic [TIME_W-1:0]     nominal_ext;
    logic [TIME_W-1:0]     dev;
    logic [WHOLE_US_W-1:0] dev_sat;
    logic [LEVEL_W-1:0]    jitter_sample;
    logic [TIME_W-1:0]     rtt_raw;
    logic [WHOLE_US_W-1:0] rtt_sat;
    logic [LEVEL_W-1:0]    rtt_sample;
    logic [LEVEL_W-1:0]    jitter_next;
    logic [LEVEL_W-1:0]    rtt_next;

    plm_ewma u_jitter_ewma (
        .i_avg    (r_jitter_average),
        .i_sample (jitter_sample),
        .i_gain   (i_cfg.jitter_gain),
        .o_avg    (jitter_next)
    );

    plm_ewma u_rtt_ewma (
        .i_avg    (r_rtt_average),
        .i_sample (rtt_sample),
        .i_gain   (i_cfg.rtt_gain),
        .o_avg    (rtt_next)
    );

    always_comb begin
        pass    = (i_item.length >= MIN_LENGTH) && (i_item.packet_magic == i_cfg.magic_word);
        is_ping = (i_item.kind == KIND_PING);
        peer_m  = i_item.peer & PEER_MASK;

        last_plus_one = {1'b0, r_last_sequence} + (SEQ_W + 1)'(1);
        seq_gap       = ({1'b0, i_item.sequence_req} > last_plus_one);

        arr_gap     = i_item.arrival_time - r_last_arrival;
        nominal_ext = TIME_W'(i_cfg.nominal_gap_us);
        dev         = (arr_gap >= nominal_ext) ? (arr_gap - nominal_ext)
                                               : (nominal_ext - arr_gap);
        dev_sat     = (|dev[TIME_W-1:WHOLE_US_W]) ? '1 : dev[WHOLE_US_W-1:0];
        jitter_sample = {dev_sat, {FRACTION_BITS{1'b0}}};

        rtt_raw    = i_item.arrival_time - i_item.sent_time;
        rtt_sat    = (|rtt_raw[TIME_W-1:WHOLE_US_W]) ? '1 : rtt_raw[WHOLE_US_W-1:0];
        rtt_sample = {rtt_sat, {FRACTION_BITS{1'b0}}};

        n_last_sequence  = r_last_sequence;
        n_ping_count     = r_ping_count;
        n_loss_count     = r_loss_count;
        n_last_arrival   = r_last_arrival;
        n_arrival_seen   = r_arrival_seen;
        n_jitter_average = r_jitter_average;
        n_rtt_average    = r_rtt_average;
        n_rtt_seeded     = r_rtt_seeded;
        n_pongs_seen     = r_pongs_seen;
        n_locked_peer    = r_locked_peer;
        n_peer_is_locked = r_peer_is_locked;

        o_result = '0;
        o_result.status = ST_DROP;

        if (pass) begin
            if (!r_peer_is_locked) begin
                n_locked_peer    = peer_m;
                n_peer_is_locked = 1'b1;
            end
            if (is_ping) begin
                if ((r_ping_count != '0) && seq_gap) begin
                    n_loss_count = r_loss_count + i_item.sequence_req - r_last_sequence
                                   - COUNT_W'(1);
                end
                if (r_arrival_seen) begin
                    n_jitter_average = jitter_next;
                end
                n_last_sequence = i_item.sequence_req;
                n_last_arrival  = i_item.arrival_time;
                n_arrival_seen  = 1'b1;
                n_ping_count    = r_ping_count + COUNT_W'(1);
                o_result.status         = ST_PING;
                o_result.echo_peer      = peer_m;
                o_result.echo_sequence  = i_item.sequence_req;
                o_result.echo_sent_time = i_item.sent_time;
            end else begin
                n_rtt_average = r_rtt_seeded ? rtt_next : rtt_sample;
                n_rtt_seeded  = 1'b1;
                n_pongs_seen  = r_pongs_seen + COUNT_W'(1);
                o_result.status = ST_PONG;
            end
        end

        o_result.received_count    = n_ping_count;
        o_result.lost_total        = n_loss_count;
        o_result.jitter_level      = LEVEL_OUT_W'(n_jitter_average);
        o_result.rtt_level         = LEVEL_OUT_W'(n_rtt_average);
        o_result.rtt_ready         = n_rtt_seeded;
        o_result.pong_count        = n_pongs_seen;
        o_result.locked_peer_index = n_locked_peer;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_sequence  <= '0;
            r_ping_count     <= '0;
            r_loss_count     <= '0;
            r_last_arrival   <= '0;
            r_arrival_seen   <= 1'b0;
            r_jitter_average <= '0;
            r_rtt_average    <= '0;
            r_rtt_seeded     <= 1'b0;
            r_pongs_seen     <= '0;
            r_locked_peer    <= '0;
            r_peer_is_locked <= 1'b0;
        end else if (i_fire) begin
            r_last_sequence  <= n_last_sequence;
            r_ping_count     <= n_ping_count;
            r_loss_count     <= n_loss_count;
            r_last_arrival   <= n_last_arrival;
            r_arrival_seen   <= n_arrival_seen;
            r_jitter_average <= n_jitter_average;
            r_rtt_average    <= n_rtt_average;
            r_rtt_seeded     <= n_rtt_seeded;
            r_pongs_seen     <= n_pongs_seen;
            r_locked_peer    <= n_locked_peer;
            r_peer_is_locked <= n_peer_is_locked;
        end
    end

endmodule

FILE: rtl/ping_link_quality_monitor_core.sv
// ----------------------------------------------------------------------------
// ping_link_quality_monitor_core
// Ping link quality monitor: filters received ping-protocol packets, echoes
// pings as pongs and tracks loss, jitter and round trip averages.
//
// Channels: i_in takes one received packet and its arrival time per beat,
// o_out returns exactly one result beat per packet, in order, and i_cfg
// writes the magic word, nominal gap and the two EWMA gains by register
// index. Config beats are always taken and must only come while idle.
// A packet accepted into the input register reaches o_out from the result
// register. Throughput: one packet per cycle when unstalled; the whole update,
// with the EWMA multiply, runs between the input register and the result
// register, and the statistics state updates as each result is registered.
// Reset clears all statistics, drops any held packet or result and reloads
// the config defaults. When the receiver stalls, the result is held, one
// more packet is taken into the input register, and i_in.ready then drops.
// ----------------------------------------------------------------------------
module ping_link_quality_monitor_core (
    input  logic     i_clk,
    input  logic     i_rst_n,
    plm_in_if.sink   i_in,
    plm_out_if.source o_out,
    plm_cfg_if.sink  i_cfg
);
    import plm_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result result;
    t_cfg    cfg;
    logic    advance;
    logic    in_beat;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_beat    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    plm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_index (i_cfg.reg_index),
        .i_data  (i_cfg.wdata),
        .o_cfg   (cfg)
    );

    plm_proc u_proc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_beat) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_in.peer         <= i_in.peer;
            r_in.length       <= i_in.length;
            r_in.packet_magic <= i_in.packet_magic;
            r_in.kind         <= i_in.kind;
            r_in.sequence_req <= i_in.sequence_req;
            r_in.sent_time    <= i_in.sent_time;
            r_in.arrival_time <= i_in.arrival_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.status            = r_out.status;
    assign o_out.echo_peer         = r_out.echo_peer;
    assign o_out.echo_sequence     = r_out.echo_sequence;
    assign o_out.echo_sent_time    = r_out.echo_sent_time;
    assign o_out.received_count    = r_out.received_count;
    assign o_out.lost_total        = r_out.lost_total;
    assign o_out.jitter_level      = r_out.jitter_level;
    assign o_out.rtt_level         = r_out.rtt_level;
    assign o_out.rtt_ready         = r_out.rtt_ready;
    assign o_out.pong_count        = r_out.pong_count;
    assign o_out.locked_peer_index = r_out.locked_peer_index;

endmodule

FILE: rtl/plm_checker.sv
// ----------------------------------------------------------------------------
// plm_checker
// Port-level checks of the monitor, bound to the top level.
// ----------------------------------------------------------------------------
module plm_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_ready,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [plm_pkg::STATUS_W-1:0]    i_status,
    input  logic [plm_pkg::PEER_W-1:0]      i_echo_peer,
    input  logic [plm_pkg::SEQ_W-1:0]       i_echo_sequence,
    input  logic [plm_pkg::TIME_W-1:0]      i_echo_sent_time,
    input  logic                            i_rtt_ready
);
    import plm_pkg::*;

    // A held result beat must stay until the receiver takes it.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat withdrawn while stalled");

    // The input side only stalls while a result is waiting on a stalled receiver.
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without output backpressure");

    // A measured pong always leaves the round trip average seeded.
    a_pong_seeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_PONG) |-> i_rtt_ready)
        else $error("pong result without seeded round trip average");

    // Only a ping carries an echo.
    a_echo_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_PING) |->
            (i_echo_peer == '0) && (i_echo_sequence == '0) && (i_echo_sent_time == '0))
        else $error("echo fields set on a non-ping result");

endmodule

bind ping_link_quality_monitor_core plm_checker u_plm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_status         (o_out.status),
    .i_echo_peer      (o_out.echo_peer),
    .i_echo_sequence  (o_out.echo_sequence),
    .i_echo_sent_time (o_out.echo_sent_time),
    .i_rtt_ready      (o_out.rtt_ready)
);
